// File: rtl/core/tpqe_pkg.sv
// ----------------------------------------------------------------------------
// tpqe_pkg
// shared constants and types of the polyline quad expander
// ----------------------------------------------------------------------------
package tpqe_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 24;
  localparam int unsigned FRAC_BITS_DEF   = 8;
  localparam int unsigned WIDTH_BITS      = 16;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 16'd256;
  localparam logic [WIDTH_BITS-1:0] WIDTH_ONE   = 16'd256;
  localparam int unsigned NORM_BITS       = 31;
  localparam int unsigned QUAD_VERTS      = 6;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_THIN,
    OP_THICK
  } op_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LOAD,
    BK_NORM,
    BK_SQRT,
    BK_DIVX,
    BK_DIVY,
    BK_EMIT,
    BK_THIN
  } bk_state_t;

endpackage

// File: rtl/core/tpqe_front.sv
// ----------------------------------------------------------------------------
// tpqe_front
// accepts points, keeps path state and issues segment or thin commands
// ----------------------------------------------------------------------------
module tpqe_front import tpqe_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic                          last,
  input  logic                          closed,
  input  logic [WIDTH_BITS-1:0]         weff,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output logic [6*COORD_WIDTH+4:0]      cmd_data
);

  logic signed [COORD_WIDTH-1:0] first_x, first_y, prev_x, prev_y;
  logic [1:0]                    points_seen;
  logic                          thick;
  op_t                           op;

  assign thick = weff > WIDTH_ONE;
  always_comb begin
    if (points_seen == 2'd0) op = OP_STORE;
    else if (thick) op = OP_THICK;
    else op = OP_THIN;
  end

  // command fields: op, held-first, last, closed, a, b, first
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid && (op != OP_STORE);
  assign cmd_data  = {op, (points_seen == 2'd1), last, closed,
                      prev_x, prev_y, px, py, first_x, first_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      points_seen <= 2'd0;
      first_x <= '0; first_y <= '0; prev_x <= '0; prev_y <= '0;
    end else if (in_valid && in_ready) begin
      if (points_seen == 2'd0) begin
        first_x <= px; first_y <= py;
      end
      prev_x <= px; prev_y <= py;
      if (last) points_seen <= 2'd0;
      else if (points_seen != 2'd2) points_seen <= points_seen + 2'd1;
    end
  end

endmodule

// File: rtl/core/tpqe_top_dummy.sv
// ----------------------------------------------------------------------------
// tpqe_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module tpqe_queue import tpqe_pkg::*; #(
  parameter int unsigned DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2];
  logic          wp, rp;
  logic [1:0]    cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

// File: rtl/core/tpqe_back.sv
// ----------------------------------------------------------------------------
// tpqe_back
// normal, square root, offset divide and vertex emission for one command
// ----------------------------------------------------------------------------
module tpqe_back import tpqe_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [6*COORD_WIDTH+4:0]      cmd_data,
  input  logic [WIDTH_BITS-1:0]         weff,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] vx,
  output logic signed [COORD_WIDTH-1:0] vy,
  output logic                          vtri,
  output logic                          vloop,
  output logic                          vend,
  output logic                          vrun
);

  localparam int unsigned CW  = COORD_WIDTH;
  localparam int unsigned DW  = CW + 1;
  localparam int unsigned CMW = 6 * CW + 5;
  localparam int unsigned KW  = WIDTH_BITS + FRAC_BITS;
  localparam int unsigned NW  = NORM_BITS;
  localparam int unsigned MW  = (DW > NW) ? DW : NW;
  localparam int unsigned PW  = NW + KW;
  localparam int unsigned LW  = NW + 9;
  localparam int unsigned SW  = 2 * NW + 2;
  localparam int unsigned RW  = NW + 1;
  localparam int unsigned XW  = ((CW > FRAC_BITS + 9) ? CW : FRAC_BITS + 9) + 2;
  localparam logic signed [XW-1:0] SMAX = XW'((64'sd1 <<< (CW-1)) - 1);
  localparam logic signed [XW-1:0] SMIN = -XW'(64'sd1 <<< (CW-1));
  localparam logic [MW-1:0] NORM_LO = MW'(64'd1 << 29);
  localparam logic [MW-1:0] NORM_HI = MW'(64'd1 << 30);

  bk_state_t state, state_next;

  logic signed [CW-1:0] ax, ay, bx, by, fx, fy;
  logic                 c_held, c_last, c_closed, c_second;
  op_t                  cmd_op;
  logic [MW-1:0]        mx, my;
  logic                 sx, sy;
  logic [SW-1:0]        rad, rem;
  logic [RW-1:0]        root;
  logic [5:0]           sq_cnt;
  logic [PW-1:0]        num;
  logic [LW-1:0]        den;
  logic [PW:0]          drem;
  logic [PW-1:0]        quo;
  logic [6:0]           dv_cnt;
  logic [NW-1:0]        oxm, oym;
  logic [2:0]           vi;
  logic                 thin_phase;

  assign cmd_op = op_t'(cmd_data[CMW-1 -: 2]);

  logic signed [DW-1:0] ddx, ddy;
  assign ddx = DW'(bx) - DW'(ax);
  assign ddy = DW'(by) - DW'(ay);

  logic [MW-1:0] mm;
  assign mm = (mx > my) ? mx : my;

  logic signed [XW-1:0] ox, oy, sumx, sumy, basex, basey;
  logic                 useb, neg;
  always_comb begin
    ox = sy ? XW'(oxm) : -XW'(oxm);
    oy = sx ? -XW'(oym) : XW'(oym);
    useb = (vi == 3'd1) || (vi == 3'd2) || (vi == 3'd4);
    neg  = (vi == 3'd2) || (vi == 3'd4) || (vi == 3'd5);
    basex = useb ? XW'(bx) : XW'(ax);
    basey = useb ? XW'(by) : XW'(ay);
    sumx = neg ? basex - ox : basex + ox;
    sumy = neg ? basey - oy : basey + oy;
  end

  function automatic logic signed [CW-1:0] sat(input logic signed [XW-1:0] v);
    if (v > SMAX) sat = SMAX[CW-1:0];
    else if (v < SMIN) sat = SMIN[CW-1:0];
    else sat = v[CW-1:0];
  endfunction

  logic [SW-1:0] sq_shift, sq_sub;
  logic          sq_take;
  logic [RW-1:0] root_new;
  assign sq_shift = {rem[SW-3:0], rad[SW-1:SW-2]};
  assign sq_sub   = SW'({root, 2'b01});
  assign sq_take  = sq_shift >= sq_sub;
  assign root_new = {root[RW-2:0], sq_take};

  logic [PW:0]   dsub;
  assign dsub = {drem[PW-1:0], num[PW-1]} - (PW+1)'(den);

  logic more;
  assign more = c_last && c_closed && !c_second && !((bx == fx) && (by == fy));

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) state_next = (cmd_op == OP_THIN) ? BK_THIN : BK_LOAD;
      end
      BK_LOAD: state_next = (ddx == '0 && ddy == '0) ? (more ? BK_LOAD : BK_IDLE)
                                                       : BK_NORM;
      BK_NORM: if ((mm < NORM_LO && mm != '0) || mm >= NORM_HI) state_next = BK_NORM;
               else state_next = BK_SQRT;
      BK_SQRT: if (sq_cnt == '0) state_next = BK_DIVX;
      BK_DIVX: if (dv_cnt == '0) state_next = BK_DIVY;
      BK_DIVY: if (dv_cnt == '0) state_next = BK_EMIT;
      BK_EMIT: if (out_ready && vi == 3'(QUAD_VERTS-1))
                 state_next = more ? BK_LOAD : BK_IDLE;
      BK_THIN: if (out_ready && (thin_phase || !c_held)) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: if (cmd_valid) begin
        c_held   <= cmd_data[CMW-3];
        c_last   <= cmd_data[CMW-4];
        c_closed <= cmd_data[CMW-5];
        {ax, ay, bx, by, fx, fy} <= cmd_data[6*CW-1:0];
        c_second <= 1'b0; vi <= '0; thin_phase <= 1'b0;
      end
      BK_LOAD: begin
        if (ddx == '0 && ddy == '0) begin
          if (more) begin
            ax <= bx; ay <= by; bx <= fx; by <= fy; c_second <= 1'b1;
          end
        end else begin
          sx <= ddx[DW-1]; sy <= ddy[DW-1];
          mx <= MW'(ddx[DW-1] ? -ddx : ddx);
          my <= MW'(ddy[DW-1] ? -ddy : ddy);
        end
      end
      BK_NORM: begin
        if (mm >= NORM_HI) begin
          mx <= mx >> 1; my <= my >> 1;
        end else if (mm < NORM_LO) begin
          mx <= mx << 1; my <= my << 1;
        end else begin
          rad <= SW'(mx[NW-1:0]) * SW'(mx[NW-1:0]) + SW'(my[NW-1:0]) * SW'(my[NW-1:0]);
          rem <= '0; root <= '0; sq_cnt <= 6'(NW);
        end
      end
      BK_SQRT: begin
        rem  <= sq_take ? sq_shift - sq_sub : sq_shift;
        root <= root_new;
        rad  <= rad << 2;
        if (sq_cnt != '0) sq_cnt <= sq_cnt - 6'd1;
        else begin
          den  <= LW'(root_new) << 9;
          num  <= PW'(my[NW-1:0]) * (PW'(weff) << FRAC_BITS) + (PW'(root_new) << 8);
          drem <= '0; dv_cnt <= 7'(PW);
        end
      end
      BK_DIVX, BK_DIVY: begin
        if (dv_cnt != '0) begin
          if (!dsub[PW]) begin
            drem <= dsub; quo <= {quo[PW-2:0], 1'b1};
          end else begin
            drem <= {drem[PW-1:0], num[PW-1]}; quo <= {quo[PW-2:0], 1'b0};
          end
          num <= num << 1;
          dv_cnt <= dv_cnt - 7'd1;
        end else if (state == BK_DIVX) begin
          oxm  <= NW'(quo);
          num  <= PW'(mx[NW-1:0]) * (PW'(weff) << FRAC_BITS) + PW'(den >> 1);
          drem <= '0; dv_cnt <= 7'(PW);
        end else oym <= NW'(quo);
      end
      BK_EMIT: if (out_ready) begin
        if (vi == 3'(QUAD_VERTS-1)) begin
          vi <= '0;
          if (more) begin
            ax <= bx; ay <= by; bx <= fx; by <= fy; c_second <= 1'b1;
          end
        end else vi <= vi + 3'd1;
      end
      BK_THIN: if (out_ready) thin_phase <= 1'b1;
      default: ;
    endcase
  end

  // output fields
  always_comb begin
    out_valid = (state == BK_EMIT) || (state == BK_THIN);
    vtri = state == BK_EMIT;
    vloop = 1'b0; vend = 1'b0; vrun = 1'b0;
    if (state == BK_THIN) begin
      if (c_held && !thin_phase) begin
        vx = ax; vy = ay;
      end else begin
        vx = bx; vy = by; vrun = 1'b1; vend = c_last; vloop = c_last && c_closed;
      end
    end else begin
      vx = sat(sumx); vy = sat(sumy);
      vrun = (vi == 3'(QUAD_VERTS-1)) && !more;
      vend = vrun && c_last;
    end
  end

endmodule

// File: rtl/core/thick_polyline_quad_expander_unit.sv
// ----------------------------------------------------------------------------
// thick_polyline_quad_expander_unit
// strokes a polyline into line-strip or triangle-list vertices
// ----------------------------------------------------------------------------
// Points are accepted whenever the two-entry command queue has room; a first
// point only updates the path state. The back runs one command at a time. A
// thin point is picked up and then emits one or two line vertices. A thick
// segment is picked up, loaded and normalised by shifting the delta (one
// shift per cycle, more shifts for short segments), then runs a square root,
// two divides and six vertex emits, which stall while the output is not ready.
// A closing point runs a second segment; a zero-length segment emits nothing.
module thick_polyline_quad_expander_unit import tpqe_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic                          last_point,
  input  logic                          closed,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [WIDTH_BITS-1:0]         cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] vertex_x,
  output logic signed [COORD_WIDTH-1:0] vertex_y,
  output logic                          is_triangle,
  output logic                          loop_back,
  output logic                          path_end,
  output logic                          last_of_run
);

  localparam int unsigned QW = 6 * COORD_WIDTH + 5;

  logic [WIDTH_BITS-1:0] line_width, weff;
  logic                  fq_valid, fq_ready, bq_valid, bq_ready;
  logic [QW-1:0]         fq_data, bq_data;

  assign cfg_ready = 1'b1;
  assign weff = (line_width == '0) ? WIDTH_ONE : line_width;

  always_ff @(posedge clk) begin
    if (rst) line_width <= WIDTH_RESET;
    else if (cfg_valid && cfg_ready) line_width <= cfg_data;
  end

  tpqe_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready, .px(point_x), .py(point_y),
    .last(last_point), .closed, .weff,
    .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd_data(fq_data)
  );

  tpqe_queue #(.DW(QW)) u_queue (
    .clk, .rst, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
  );

  tpqe_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .cmd_valid(bq_valid), .cmd_ready(bq_ready), .cmd_data(bq_data),
    .weff,
    .out_valid, .out_ready, .vx(vertex_x), .vy(vertex_y), .vtri(is_triangle),
    .vloop(loop_back), .vend(path_end), .vrun(last_of_run)
  );

  a_end_has_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && path_end |-> last_of_run) else $error("path end without run end");
  a_loop_thin: assert property (@(posedge clk) disable iff (rst)
    out_valid && loop_back |-> !is_triangle) else $error("loop flag on triangle");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams polylines into the quad expander and checks every emitted vertex
// against an in-bench stroke predictor, over thin and thick widths, closed and
// open paths, zero-length segments, saturation and mid-path width changes,
// with random idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
  import tpqe_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 600;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
    logic                 closed;
  } point_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 tri_v;
    logic                 loopb;
    logic                 pend;
    logic                 lrun;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic last_point = 1'b0;
  logic closed = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WIDTH_BITS-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] vertex_x;
  logic signed [CW-1:0] vertex_y;
  logic is_triangle;
  logic loop_back;
  logic path_end;
  logic last_of_run;

  point_t  pending_points[$];
  vertex_t expected_verts[$];
  vertex_t run_verts[$];

  int send_idle = 33;
  int recv_idle = 45;
  int beats_sent = 0;
  int beats_taken = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  logic [WIDTH_BITS-1:0] width_reg = WIDTH_RESET;
  longint first_px = 0, first_py = 0, prev_px = 0, prev_py = 0;
  int points_held = 0;

  always #10 clk = ~clk;

  thick_polyline_quad_expander_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .last_point(last_point), .closed(closed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .vertex_x(vertex_x), .vertex_y(vertex_y), .is_triangle(is_triangle),
    .loop_back(loop_back), .path_end(path_end), .last_of_run(last_of_run)
  );

  function automatic longint clamp_coord(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint offset_part(longint unsigned mag, bit neg, longint unsigned k,
                                         longint unsigned len);
    longint unsigned den, q;
    den = len << 9;
    q = (mag * k + den / 2) / den;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  task automatic emit_vertex(longint x, longint y, bit tri_v);
    vertex_t v;
    v.x = CW'(clamp_coord(x));
    v.y = CW'(clamp_coord(y));
    v.tri_v = tri_v;
    v.loopb = 1'b0;
    v.pend = 1'b0;
    v.lrun = 1'b0;
    run_verts.push_back(v);
  endtask

  task automatic stroke_segment(longint ax, longint ay, longint bx, longint by,
                                longint unsigned w);
    longint dx, dy, ox, oy;
    longint unsigned mx, my, m, len, k;
    dx = bx - ax;
    dy = by - ay;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    m = mx > my ? mx : my;
    if (m == 0) return;
    while (m >= 64'h4000_0000) begin
      mx = mx >> 1; my = my >> 1; m = m >> 1;
    end
    while (m < 64'h2000_0000) begin
      mx = mx << 1; my = my << 1; m = m << 1;
    end
    len = int_root(mx * mx + my * my);
    k = w << FB;
    ox = offset_part(my, dy > 0, k, len);
    oy = offset_part(mx, dx < 0, k, len);
    emit_vertex(ax + ox, ay + oy, 1'b1);
    emit_vertex(bx + ox, by + oy, 1'b1);
    emit_vertex(bx - ox, by - oy, 1'b1);
    emit_vertex(ax + ox, ay + oy, 1'b1);
    emit_vertex(bx - ox, by - oy, 1'b1);
    emit_vertex(ax - ox, ay - oy, 1'b1);
  endtask

  task automatic expand_point(point_t p);
    longint x, y;
    longint unsigned w;
    int n;
    x = p.x;
    y = p.y;
    w = (width_reg == 0) ? 256 : width_reg;
    run_verts.delete();
    if (points_held == 0) begin
      first_px = x;
      first_py = y;
    end else if (w <= 256) begin
      if (points_held == 1) emit_vertex(prev_px, prev_py, 1'b0);
      emit_vertex(x, y, 1'b0);
      if (p.last) run_verts[run_verts.size() - 1].loopb = p.closed;
    end else begin
      stroke_segment(prev_px, prev_py, x, y, w);
      if (p.last && p.closed) stroke_segment(x, y, first_px, first_py, w);
    end
    n = run_verts.size();
    if (n > 0) begin
      run_verts[n - 1].lrun = 1'b1;
      if (p.last) run_verts[n - 1].pend = 1'b1;
    end
    foreach (run_verts[i]) expected_verts.push_back(run_verts[i]);
    prev_px = x;
    prev_py = y;
    if (p.last) points_held = 0;
    else if (points_held < 2) points_held++;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && beats_taken != beats_sent) begin
      in_valid <= 1'b1;
    end else if (pending_points.size() > 0 && $urandom_range(99) >= send_idle) begin
      point_t p;
      p = pending_points.pop_front();
      point_x <= p.x;
      point_y <= p.y;
      last_point <= p.last;
      closed <= p.closed;
      in_valid <= 1'b1;
      beats_sent <= beats_sent + 1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 1500;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) width_reg = cfg_data;
      if (in_valid && in_ready) begin
        point_t p;
        p.x = point_x;
        p.y = point_y;
        p.last = last_point;
        p.closed = closed;
        expand_point(p);
        beats_taken <= beats_taken + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_verts.size() == 0) begin
          report_mismatch("unexpected beat, vertex_x", vertex_x, 0);
        end else begin
          vertex_t e;
          e = expected_verts.pop_front();
          if (vertex_x !== e.x) report_mismatch("vertex_x", vertex_x, e.x);
          if (vertex_y !== e.y) report_mismatch("vertex_y", vertex_y, e.y);
          if (is_triangle !== e.tri_v) report_mismatch("is_triangle", is_triangle, e.tri_v);
          if (loop_back !== e.loopb) report_mismatch("loop_back", loop_back, e.loopb);
          if (path_end !== e.pend) report_mismatch("path_end", path_end, e.pend);
          if (last_of_run !== e.lrun) report_mismatch("last_of_run", last_of_run, e.lrun);
        end
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic queue_point(longint x, longint y, bit last, bit cl);
    point_t p;
    p.x = CW'(x);
    p.y = CW'(y);
    p.last = last;
    p.closed = cl;
    pending_points.push_back(p);
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_valid || beats_taken != beats_sent ||
           expected_verts.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(logic [WIDTH_BITS-1:0] w);
    wait_drained();
    @(negedge clk);
    cfg_data <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic longint pick_coord(longint prev);
    int r;
    r = $urandom_range(9);
    if (r == 0) return longint'($signed(CW'($urandom)));
    if (r == 1) return prev;
    if (r == 2) return $urandom_range(1) ? CMAX : CMIN;
    if (r < 6) return clamp_coord(prev + $signed($urandom_range(8192)) - 4096);
    return $signed($urandom_range(131072)) - 65536;
  endfunction

  task automatic queue_random_paths(int count);
    int left, n;
    longint x, y;
    left = count;
    x = 0;
    y = 0;
    while (left > 0) begin
      n = $urandom_range(6, 1);
      if (n > left) n = left;
      for (int i = 0; i < n; i++) begin
        x = pick_coord(x);
        y = pick_coord(y);
        queue_point(x, y, i == n - 1, 1'($urandom_range(1)));
      end
      left -= n;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // thin, zero width taken as one
    write_width(16'd0);
    queue_point(CMAX, CMAX, 0, 0);
    queue_point(CMIN, CMIN, 1, 1);
    queue_point(5, -7, 1, 0);
    queue_point(0, 0, 0, 1);
    queue_point(256, 0, 0, 0);
    queue_point(256, 256, 1, 0);

    // widest stroke, saturation and degenerate segments
    write_width(16'hFFFF);
    queue_point(CMIN, CMIN, 0, 0);
    queue_point(CMAX, CMAX, 1, 1);
    queue_point(100, 100, 0, 0);
    queue_point(100, 100, 0, 0);
    queue_point(1000, -300, 0, 0);
    queue_point(1000, -300, 1, 1);
    queue_point(0, 0, 0, 0);
    queue_point(0, 0, 1, 0);
    queue_point(10, 10, 0, 0);
    queue_point(10, 10, 1, 1);
    queue_point(-42, 77, 1, 1);

    // width changed in the middle of a path
    write_width(16'd512);
    queue_point(0, 0, 0, 0);
    queue_point(512, 1024, 0, 0);
    write_width(16'd256);
    queue_point(-300, 50, 1, 1);

    write_width(16'd384);
    queue_random_paths(35);

    send_idle = 45;
    recv_idle = 33;
    write_width(16'd128);
    queue_random_paths(35);
    write_width(WIDTH_BITS'($urandom_range(65535, 257)));
    queue_random_paths(35);

    send_idle = 0;
    recv_idle = 0;
    write_width(16'd257);
    queue_random_paths(35);
    hold_req = 1'b1;

    wait_drained();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
